[src/wfd_pkg.sv]
// shared types, constants and helper functions of the wiegand field decoder
package wfd_pkg;

    localparam int unsigned SAMPLE_W = 64;
    localparam int unsigned VALUE_W  = 64;
    localparam int unsigned LEN_W    = 7;
    localparam int unsigned KIND_W   = 2;
    localparam int unsigned REG_W    = 2;

    typedef logic [SAMPLE_W-1:0] t_sample;
    typedef logic [VALUE_W-1:0]  t_value;
    typedef logic [LEN_W-1:0]    t_len;
    typedef logic [KIND_W-1:0]   t_kind;
    typedef logic [REG_W-1:0]    t_reg_idx;

    // longest field that can be gathered
    localparam t_len LEN_MAX   = t_len'(VALUE_W);
    localparam t_len TAKEN_SAT = '1;

    // slots of one frame
    typedef enum logic [2:0] {
        SLOT_LEAD_PAR  = 3'd0,
        SLOT_SITE      = 3'd1,
        SLOT_FACILITY  = 3'd2,
        SLOT_CARD      = 3'd3,
        SLOT_TRAIL_PAR = 3'd4
    } t_slot;

    // result kinds
    localparam t_kind KIND_PARITY   = 2'd0;
    localparam t_kind KIND_SITE     = 2'd1;
    localparam t_kind KIND_FACILITY = 2'd2;
    localparam t_kind KIND_CARD     = 2'd3;

    // configuration register indexes
    localparam t_reg_idx REG_SITE_BITS     = 2'd0;
    localparam t_reg_idx REG_FACILITY_BITS = 2'd1;
    localparam t_reg_idx REG_CARD_BITS     = 2'd2;

    // register reset values
    localparam t_len SITE_BITS_RST     = 7'd0;
    localparam t_len FACILITY_BITS_RST = 7'd8;
    localparam t_len CARD_BITS_RST     = 7'd16;

    // clamp a configured length to the field width
    function automatic t_len cap_len(input t_len v);
        return (v > LEN_MAX) ? LEN_MAX : v;
    endfunction

    // length of a slot under the current configuration
    function automatic t_len slot_len(input t_slot slot, input t_len site,
                                      input t_len facility, input t_len card);
        t_len len;
        unique case (slot)
            SLOT_SITE:     len = cap_len(site);
            SLOT_FACILITY: len = cap_len(facility);
            SLOT_CARD:     len = cap_len(card);
            default:       len = t_len'(1);
        endcase
        return len;
    endfunction

    // kind reported for a slot
    function automatic t_kind slot_kind(input t_slot slot);
        t_kind kind;
        unique case (slot)
            SLOT_SITE:     kind = KIND_SITE;
            SLOT_FACILITY: kind = KIND_FACILITY;
            SLOT_CARD:     kind = KIND_CARD;
            default:       kind = KIND_PARITY;
        endcase
        return kind;
    endfunction

endpackage

[src/wfd_pulse_if.sv]
// pulse, field and configuration channel interfaces
interface wfd_pulse_if;
    logic               valid;
    logic               ready;
    logic               pulse_line;
    wfd_pkg::t_sample   pulse_start;
    wfd_pkg::t_sample   pulse_end;

    modport source (output valid, pulse_line, pulse_start, pulse_end, input ready);
    modport sink   (input valid, pulse_line, pulse_start, pulse_end, output ready);
endinterface

interface wfd_field_if;
    logic               valid;
    logic               ready;
    wfd_pkg::t_kind     field_kind;
    wfd_pkg::t_value    field_value;
    wfd_pkg::t_sample   field_first;
    wfd_pkg::t_sample   field_last;

    modport source (output valid, field_kind, field_value, field_first, field_last,
                    input ready);
    modport sink   (input valid, field_kind, field_value, field_first, field_last,
                    output ready);
endinterface

interface wfd_cfg_if;
    logic               valid;
    logic               ready;
    wfd_pkg::t_reg_idx  reg_index;
    wfd_pkg::t_len      wr_data;

    modport source (output valid, reg_index, wr_data, input ready);
    modport sink   (input valid, reg_index, wr_data, output ready);
endinterface

[src/wiegand_field_decoder.sv]
// wiegand field decoder top level
//
//   channel   dir  handshake      payload
//   i_pulse   in   valid/ready    pulse_line, pulse_start, pulse_end
//   o_field   out  valid/ready    field_kind, field_value, field_first, field_last
//   i_cfg     in   valid/ready    reg_index, wr_data (ready always high)
//
// one pulse transaction per cycle while the result register is free or being
// taken; a pulse passes an input register, then the slot/shift update and the
// result register, which holds each finished field for the output channel.
// reset (synchronous, active low) returns to the leading parity slot with
// default field lengths. a stalled output holds its result; the input stage
// keeps accepting as long as the result register is free or being taken.
module wiegand_field_decoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    wfd_pulse_if.sink   i_pulse,
    wfd_field_if.source o_field,
    wfd_cfg_if.sink     i_cfg
);
    import wfd_pkg::*;

    // configuration registers
    t_len    r_site_bits;
    t_len    r_facility_bits;
    t_len    r_card_bits;

    // input stage
    logic    r_in_valid;
    logic    r_in_line;
    t_sample r_in_start;
    t_sample r_in_end;

    // decoder state
    t_slot   r_slot;
    t_slot   n_slot;
    t_len    r_taken;
    t_len    n_taken;
    t_value  r_shift;
    t_value  n_shift;
    t_sample r_first;
    t_sample n_first;

    // result register
    logic    r_out_valid;
    t_kind   r_out_kind;
    t_value  r_out_value;
    t_sample r_out_first;
    t_sample r_out_last;

    // working values of the update stage
    t_slot   eff_slot;
    t_len    eff_len;
    t_len    taken_inc;
    t_value  shift_in;
    t_sample first_cur;
    logic    done;
    logic    can_adv;
    logic    fire;

    // handshakes
    assign can_adv       = !r_out_valid || o_field.ready;
    assign fire          = r_in_valid && can_adv;
    assign i_pulse.ready = !r_in_valid || can_adv;
    assign i_cfg.ready   = 1'b1;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_site_bits     <= SITE_BITS_RST;
            r_facility_bits <= FACILITY_BITS_RST;
            r_card_bits     <= CARD_BITS_RST;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.reg_index)
                REG_SITE_BITS:     r_site_bits     <= i_cfg.wr_data;
                REG_FACILITY_BITS: r_facility_bits <= i_cfg.wr_data;
                REG_CARD_BITS:     r_card_bits     <= i_cfg.wr_data;
                default:           ;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_pulse.ready) begin
            r_in_valid <= i_pulse.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_pulse.valid && i_pulse.ready) begin
            r_in_line  <= i_pulse.pulse_line;
            r_in_start <= i_pulse.pulse_start;
            r_in_end   <= i_pulse.pulse_end;
        end
    end

    // slot selection, skipping empty fields at the start of a slot
    always_comb begin
        eff_slot  = (r_slot > SLOT_TRAIL_PAR) ? SLOT_LEAD_PAR : r_slot;
        first_cur = r_first;
        if (r_taken == '0) begin
            if (eff_slot == SLOT_SITE && cap_len(r_site_bits) == '0) begin
                eff_slot = SLOT_FACILITY;
            end
            if (eff_slot == SLOT_FACILITY && cap_len(r_facility_bits) == '0) begin
                eff_slot = SLOT_CARD;
            end
            if (eff_slot == SLOT_CARD && cap_len(r_card_bits) == '0) begin
                eff_slot = SLOT_TRAIL_PAR;
            end
            first_cur = r_in_start;
        end
        eff_len   = slot_len(eff_slot, r_site_bits, r_facility_bits, r_card_bits);
        shift_in  = {r_shift[VALUE_W-2:0], r_in_line};
        taken_inc = (r_taken == TAKEN_SAT) ? TAKEN_SAT : r_taken + t_len'(1);
        done      = (taken_inc >= eff_len);
    end

    // next decoder state
    always_comb begin
        n_slot  = r_slot;
        n_taken = r_taken;
        n_shift = r_shift;
        n_first = r_first;
        if (fire) begin
            n_first = first_cur;
            if (done) begin
                n_slot  = (eff_slot == SLOT_TRAIL_PAR) ? SLOT_LEAD_PAR
                                                       : t_slot'(eff_slot + 3'd1);
                n_taken = '0;
                n_shift = '0;
            end else begin
                n_slot  = eff_slot;
                n_taken = taken_inc;
                n_shift = shift_in;
            end
        end
    end

    // decoder state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot  <= SLOT_LEAD_PAR;
            r_taken <= '0;
            r_shift <= '0;
            r_first <= '0;
        end else begin
            r_slot  <= n_slot;
            r_taken <= n_taken;
            r_shift <= n_shift;
            r_first <= n_first;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire && done) begin
            r_out_valid <= 1'b1;
        end else if (o_field.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && done) begin
            r_out_kind  <= slot_kind(eff_slot);
            r_out_value <= shift_in;
            r_out_first <= first_cur;
            r_out_last  <= r_in_end;
        end
    end

    // output channel
    assign o_field.valid       = r_out_valid;
    assign o_field.field_kind  = r_out_kind;
    assign o_field.field_value = r_out_value;
    assign o_field.field_first = r_out_first;
    assign o_field.field_last  = r_out_last;

endmodule

[src/wfd_checker.sv]
// port-level checks of the wiegand field decoder and their binding
module wfd_checker (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_out_valid,
    input logic             i_out_ready,
    input wfd_pkg::t_kind   i_out_kind,
    input wfd_pkg::t_value  i_out_value,
    input wfd_pkg::t_sample i_out_first,
    input wfd_pkg::t_sample i_out_last
);
    import wfd_pkg::*;

    // no result right after reset
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

    // a stalled result holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_out_kind) && $stable(i_out_value) &&
            $stable(i_out_first) && $stable(i_out_last))
        else $error("stalled result changed");

    // a parity result carries a single bit
    a_parity_one_bit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_kind == KIND_PARITY |-> i_out_value[VALUE_W-1:1] == '0)
        else $error("parity result wider than one bit");

endmodule

bind wiegand_field_decoder wfd_checker u_wfd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_field.valid),
    .i_out_ready (o_field.ready),
    .i_out_kind  (o_field.field_kind),
    .i_out_value (o_field.field_value),
    .i_out_first (o_field.field_first),
    .i_out_last  (o_field.field_last)
);
